/* rtl/cscan_pkg.sv */
// Shared types and codes for the C-SCAN disk request scheduler.
// No dependencies; imported by the scan unit, the top level and the checker.
package cscan_pkg;

  localparam int STAMP_W = 32;
  localparam int WAIT_W  = 16;
  localparam int WRAP_W  = 16;
  localparam int SEEK_W  = 32;

  typedef enum logic [2:0] {
    EV_IDLE     = 3'd0,
    EV_MOVED    = 3'd1,
    EV_SERVED   = 3'd2,
    EV_WRAPPED  = 3'd3,
    EV_ACCEPTED = 3'd4,
    EV_DROPPED  = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_SERVE,
    OP_WRAP
  } op_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic match_en;
  } scan_ctrl_t;

  typedef struct packed {
    logic free_found;
    logic hit_found;
    logic min_found;
  } scan_stat_t;

endpackage

/* rtl/cscan_slot_mem.sv */
// Slot table memory: cylinder and arrival stamp per pending request.
// One write port, one read port with registered data. No dependencies.
module cscan_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 42,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/cscan_scan.sv */
// Scan accumulator: walks the slot table one entry a cycle and keeps the
// first free slot, the first slot at the head and the lowest cylinder at or
// above the floor. Depends on cscan_pkg.
module cscan_scan
  import cscan_pkg::*;
#(
  parameter int CYLINDER_BITS = 10,
  parameter int IDX_W         = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scan_ctrl_t               ctrl,
  input  logic                     slot_valid,
  input  logic [IDX_W-1:0]         idx,
  input  logic [CYLINDER_BITS-1:0] rd_cyl,
  input  logic [STAMP_W-1:0]       rd_arr,
  input  logic [CYLINDER_BITS-1:0] floor_cyl,
  output scan_stat_t               stat,
  output logic [IDX_W-1:0]         free_idx,
  output logic [IDX_W-1:0]         hit_idx,
  output logic [STAMP_W-1:0]       hit_arr,
  output logic [CYLINDER_BITS-1:0] min_cyl
);

  scan_stat_t               stat_r, stat_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic [STAMP_W-1:0]       hit_arr_r, hit_arr_nxt;
  logic [CYLINDER_BITS-1:0] min_cyl_r, min_cyl_nxt;
  logic                     is_hit;
  logic                     is_min;

  always_comb begin
    stat_nxt     = stat_r;
    free_idx_nxt = free_idx_r;
    hit_idx_nxt  = hit_idx_r;
    hit_arr_nxt  = hit_arr_r;
    min_cyl_nxt  = min_cyl_r;
    is_hit = ctrl.match_en && !stat_r.hit_found && (rd_cyl == floor_cyl);
    is_min = (rd_cyl >= floor_cyl) && (!stat_r.min_found || (rd_cyl < min_cyl_r));
    if (ctrl.clear) begin
      stat_nxt = '0;
    end else if (ctrl.sample) begin
      if (!slot_valid) begin
        if (!stat_r.free_found) begin
          stat_nxt.free_found = 1'b1;
          free_idx_nxt        = idx;
        end
      end else if (is_hit) begin
        // first request at the head is the one served; it leaves the table
        stat_nxt.hit_found = 1'b1;
        hit_idx_nxt        = idx;
        hit_arr_nxt        = rd_arr;
      end else if (is_min) begin
        stat_nxt.min_found = 1'b1;
        min_cyl_nxt        = rd_cyl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
    end else begin
      stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_arr_r  <= hit_arr_nxt;
    min_cyl_r  <= min_cyl_nxt;
  end

  assign stat     = stat_r;
  assign free_idx = free_idx_r;
  assign hit_idx  = hit_idx_r;
  assign hit_arr  = hit_arr_r;
  assign min_cyl  = min_cyl_r;

endmodule

/* rtl/cscan_disk_request_scheduler_top.sv */
// C-SCAN disk request scheduler, top level: control FSM, head state, counters.
// Depends on cscan_pkg, cscan_slot_mem and cscan_scan.
//
// Usage: drive in_mode and in_cylinder with start high; the request is taken
// at a rising edge where start is high and busy is low. in_mode 0 adds a
// cylinder to the pending table, in_mode 1 is a tick that moves the head,
// serves the request at the head or wraps to the lowest pending cylinder.
// Every request yields exactly one result, shown for one cycle with out_strobe.
// out_head_position, out_total_seek, out_wrap_count and out_pending_count are
// the state after the request while out_strobe is high.
// A drop, an idle tick or a head move gives its result in the cycle after
// acceptance and busy stays low. A table add, a serve or a wrap reads the
// slot memory once per entry through its single read port: busy through the
// scan, last and commit states, result in the cycle after commit; no new
// request is taken while busy.
// Reset (rst_n low, synchronous) empties the table and zeroes head, target and
// counters; slot memory contents are left as they are.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module cscan_disk_request_scheduler_top
  import cscan_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [CYLINDER_BITS-1:0]       in_cylinder,
  output logic                           out_strobe,
  output logic [2:0]                     out_event_res,
  output logic [CYLINDER_BITS-1:0]       out_head_position,
  output logic [CYLINDER_BITS-1:0]       out_served_cylinder,
  output logic [WAIT_W-1:0]              out_wait_time,
  output logic [SEEK_W-1:0]              out_total_seek,
  output logic [WRAP_W-1:0]              out_wrap_count,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] out_pending_count
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W = STAMP_W + CYLINDER_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [CYLINDER_BITS-1:0] cyl_r, cyl_nxt;
  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     rd_vld_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic [QUEUE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]         pend_r, pend_nxt;
  logic [CYLINDER_BITS-1:0] head_r, head_nxt;
  logic [CYLINDER_BITS-1:0] target_r, target_nxt;
  logic                     tvalid_r, tvalid_nxt;
  logic [STAMP_W-1:0]       mclk_r, mclk_nxt;
  logic [SEEK_W-1:0]        seek_r, seek_nxt;
  logic [WRAP_W-1:0]        wraps_r, wraps_nxt;
  logic                     strobe_r, strobe_nxt;
  ev_t                      ev_r, ev_nxt;
  logic [CYLINDER_BITS-1:0] served_r, served_nxt;
  logic [WAIT_W-1:0]        wait_r, wait_nxt;

  logic                     accept;
  logic                     full;
  logic                     go_scan;
  logic                     mem_we;
  logic [WORD_W-1:0]        mem_rdata;
  scan_ctrl_t               scan_ctrl;
  scan_stat_t               scan_stat;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         hit_idx;
  logic [STAMP_W-1:0]       hit_arr;
  logic [CYLINDER_BITS-1:0] min_cyl;
  logic [CYLINDER_BITS-1:0] floor_cyl;
  logic [STAMP_W-1:0]       age;

  assign accept  = start && (state_r == ST_IDLE);
  assign full    = (pend_r == FULL_CNT);
  assign go_scan = in_mode ? ((pend_r != '0) && (!tvalid_r || (head_r >= target_r)))
                           : !full;
  assign age     = mclk_r - hit_arr;

  cscan_slot_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (free_idx),
    .wr_data ({mclk_r, cyl_r}),
    .rd_addr (scan_idx_r),
    .rd_data (mem_rdata)
  );

  cscan_scan #(
    .CYLINDER_BITS (CYLINDER_BITS),
    .IDX_W         (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (scan_ctrl),
    .slot_valid (valid_r[rd_idx_r]),
    .idx        (rd_idx_r),
    .rd_cyl     (mem_rdata[CYLINDER_BITS-1:0]),
    .rd_arr     (mem_rdata[CYLINDER_BITS +: STAMP_W]),
    .floor_cyl  (floor_cyl),
    .stat       (scan_stat),
    .free_idx   (free_idx),
    .hit_idx    (hit_idx),
    .hit_arr    (hit_arr),
    .min_cyl    (min_cyl)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && go_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:   state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy               = (state_r != ST_IDLE);
    scan_ctrl.clear    = accept;
    scan_ctrl.sample   = rd_vld_r;
    scan_ctrl.match_en = (op_r == OP_SERVE);
    floor_cyl          = (op_r == OP_SERVE) ? head_r : '0;
    mem_we             = (state_r == ST_COMMIT) && (op_r == OP_REQ);
  end

  // datapath
  always_comb begin
    op_nxt       = op_r;
    cyl_nxt      = cyl_r;
    scan_idx_nxt = scan_idx_r;
    valid_nxt    = valid_r;
    pend_nxt     = pend_r;
    head_nxt     = head_r;
    target_nxt   = target_r;
    tvalid_nxt   = tvalid_r;
    mclk_nxt     = mclk_r;
    seek_nxt     = seek_r;
    wraps_nxt    = wraps_r;
    strobe_nxt   = 1'b0;
    ev_nxt       = ev_r;
    served_nxt   = served_r;
    wait_nxt     = wait_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cyl_nxt      = in_cylinder;
          scan_idx_nxt = '0;
          op_nxt       = !in_mode ? OP_REQ : (tvalid_r ? OP_SERVE : OP_WRAP);
          if (!go_scan) begin
            strobe_nxt = 1'b1;
            served_nxt = '0;
            wait_nxt   = '0;
            if (!in_mode) begin
              ev_nxt = EV_DROPPED;
            end else if (pend_r == '0) begin
              ev_nxt = EV_IDLE;
            end else begin
              head_nxt = head_r + 1'b1;
              mclk_nxt = mclk_r + 1'b1;
              if (seek_r != '1) begin
                seek_nxt = seek_r + 1'b1;
              end
              ev_nxt = EV_MOVED;
            end
          end
        end
      end
      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
      ST_LAST: begin
        scan_idx_nxt = '0;
      end
      ST_COMMIT: begin
        strobe_nxt = 1'b1;
        served_nxt = '0;
        wait_nxt   = '0;
        unique case (op_r)
          OP_REQ: begin
            valid_nxt[free_idx] = 1'b1;
            pend_nxt            = pend_r + 1'b1;
            ev_nxt              = EV_ACCEPTED;
            if (pend_r == '0) begin
              // empty table: head jumps to the new request
              head_nxt   = cyl_r;
              target_nxt = cyl_r;
              tvalid_nxt = 1'b1;
            end else if (!tvalid_r) begin
              if (cyl_r >= head_r) begin
                target_nxt = cyl_r;
                tvalid_nxt = 1'b1;
              end
            end else if ((cyl_r > head_r) && (cyl_r < target_r)) begin
              target_nxt = cyl_r;
            end
          end
          OP_SERVE: begin
            if (scan_stat.hit_found) begin
              valid_nxt[hit_idx] = 1'b0;
              pend_nxt           = pend_r - 1'b1;
              served_nxt         = head_r;
              wait_nxt           = (|age[STAMP_W-1:WAIT_W]) ? '1 : age[WAIT_W-1:0];
              tvalid_nxt         = scan_stat.min_found;
              target_nxt         = min_cyl;
              ev_nxt             = EV_SERVED;
            end else begin
              tvalid_nxt = 1'b0;
              ev_nxt     = EV_IDLE;
            end
          end
          OP_WRAP: begin
            head_nxt   = min_cyl;
            target_nxt = min_cyl;
            tvalid_nxt = 1'b1;
            if (wraps_r != '1) begin
              wraps_nxt = wraps_r + 1'b1;
            end
            ev_nxt = EV_WRAPPED;
          end
          default: begin
            ev_nxt = EV_IDLE;
          end
        endcase
      end
      default: begin
        scan_idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      op_r       <= OP_REQ;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      rd_idx_r   <= '0;
      valid_r    <= '0;
      pend_r     <= '0;
      head_r     <= '0;
      target_r   <= '0;
      tvalid_r   <= 1'b0;
      mclk_r     <= '0;
      seek_r     <= '0;
      wraps_r    <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      scan_idx_r <= scan_idx_nxt;
      rd_vld_r   <= (state_r == ST_SCAN);
      rd_idx_r   <= scan_idx_r;
      valid_r    <= valid_nxt;
      pend_r     <= pend_nxt;
      head_r     <= head_nxt;
      target_r   <= target_nxt;
      tvalid_r   <= tvalid_nxt;
      mclk_r     <= mclk_nxt;
      seek_r     <= seek_nxt;
      wraps_r    <= wraps_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cyl_r    <= cyl_nxt;
    ev_r     <= ev_nxt;
    served_r <= served_nxt;
    wait_r   <= wait_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_event_res       = ev_r;
  assign out_head_position   = head_r;
  assign out_served_cylinder = served_r;
  assign out_wait_time       = wait_r;
  assign out_total_seek      = seek_r;
  assign out_wrap_count      = wraps_r;
  assign out_pending_count   = pend_r;

endmodule

/* rtl/cscan_checker.sv */
// Port-level checks for the C-SCAN scheduler top level, with its bind.
// Depends on cscan_pkg and cscan_disk_request_scheduler_top.
module cscan_checker
  import cscan_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 10
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_strobe,
  input logic [2:0]                       out_event_res,
  input logic [CYLINDER_BITS-1:0]         out_head_position,
  input logic [CYLINDER_BITS-1:0]         out_served_cylinder,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] out_pending_count
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("request accepted but neither busy nor result next cycle");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_move_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_event_res == EV_MOVED)) |->
      (out_head_position == $past(out_head_position) + 1'b1))
    else $error("move did not advance head by one cylinder");

  a_serve_at_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_event_res == EV_SERVED)) |->
      ((out_served_cylinder == out_head_position) &&
       (out_pending_count == $past(out_pending_count) - 1'b1)))
    else $error("served request not at head or pending count wrong");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_event_res == EV_DROPPED)) |->
      (out_pending_count == CNT_W'(QUEUE_DEPTH)))
    else $error("request dropped with room in the table");

endmodule

bind cscan_disk_request_scheduler_top cscan_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .CYLINDER_BITS (CYLINDER_BITS)
) u_cscan_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_event_res       (out_event_res),
  .out_head_position   (out_head_position),
  .out_served_cylinder (out_served_cylinder),
  .out_pending_count   (out_pending_count)
);
